@@ sv/tde_pkg.sv @@
package tde_pkg;

    localparam int FIELD_BITS         = 32;
    localparam int DEF_TABLE_ENTRIES  = 4096;
    localparam int DEF_VERTEX_BITS    = 32;
    localparam int EPOCH_BITS         = 8;
    localparam int HASH_BITS          = 64;
    localparam int HASH_XOR_SHIFT     = 29;
    localparam int MOD_STEP_BITS      = 8;
    localparam int MOD_STEPS          = HASH_BITS / MOD_STEP_BITS;
    localparam int RES_DEPTH          = 3;

    localparam logic [FIELD_BITS-1:0] HASH_MULT_LO = 32'h7F4A7C15;
    localparam logic [FIELD_BITS-1:0] HASH_MULT_HI = 32'h9E3779B9;

    typedef enum logic [1:0] {
        EDGE_AB = 2'd0,
        EDGE_BC = 2'd1,
        EDGE_CA = 2'd2
    } edge_sel_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_CLEAR     = 9'b000000010,
        ST_HASH_MUL  = 9'b000000100,
        ST_HASH_SUM  = 9'b000001000,
        ST_HASH_MOD  = 9'b000010000,
        ST_PROBE_RD  = 9'b000100000,
        ST_PROBE_CMP = 9'b001000000,
        ST_EMIT      = 9'b010000000,
        ST_SPARE     = 9'b100000000
    } state_t;

endpackage

@@ sv/triangle_edge_dedup.sv @@
// Reset is asynchronous; after it, and when the epoch tag wraps, a clearing pass writes
// every table entry before the next triangle is handled. A triangle is taken in ST_IDLE;
// then for each edge in turn the key is hashed in ST_HASH_MUL and ST_HASH_SUM (plus
// ST_HASH_MOD steps for the remainder when the table size is not a power of two) and the
// table is probed, each probe a ST_PROBE_RD read and a ST_PROBE_CMP compare; new edges then
// go out one at a time in ST_EMIT. No new triangle is taken until the last is through.
module triangle_edge_dedup #(
    parameter int TABLE_ENTRIES = tde_pkg::DEF_TABLE_ENTRIES,
    parameter int VERTEX_BITS   = tde_pkg::DEF_VERTEX_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            start_of_mesh,
    input  logic [tde_pkg::FIELD_BITS-1:0]  vertex_a,
    input  logic [tde_pkg::FIELD_BITS-1:0]  vertex_b,
    input  logic [tde_pkg::FIELD_BITS-1:0]  vertex_c,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tde_pkg::FIELD_BITS-1:0]  edge_low,
    output logic [tde_pkg::FIELD_BITS-1:0]  edge_high,
    output logic                            last_of_triangle,
    output logic                            table_overflow
);
    import tde_pkg::*;

    localparam int  AW       = $clog2(TABLE_ENTRIES);
    localparam int  CW       = $clog2(TABLE_ENTRIES + 1);
    localparam int  KW       = 2 * VERTEX_BITS;
    localparam int  WW       = EPOCH_BITS + KW;
    localparam bit  IS_POW2  = ((64'd1 << AW) == 64'(TABLE_ENTRIES));

    logic [WW-1:0] table_mem [TABLE_ENTRIES];
    logic [WW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;

    state_t state_reg, state_next;
    logic [VERTEX_BITS-1:0] va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    edge_sel_t edge_reg, edge_next;
    logic [KW-1:0] key_reg, key_next;
    logic [2*FIELD_BITS-1:0] p0_reg, p0_next;
    logic [FIELD_BITS-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [HASH_BITS-1:0] h_reg, h_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [$clog2(MOD_STEPS)-1:0] mod_cnt_reg, mod_cnt_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] probe_reg, probe_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic pend_reg, pend_next;
    logic [VERTEX_BITS-1:0] res_lo_reg [RES_DEPTH];
    logic [VERTEX_BITS-1:0] res_hi_reg [RES_DEPTH];
    logic res_ovf_reg [RES_DEPTH];
    logic [1:0] res_cnt_reg, res_cnt_next;
    logic [1:0] emit_idx_reg, emit_idx_next;
    logic res_we;
    logic res_ovf_w;

    logic [VERTEX_BITS-1:0] ep, eq, elo, ehi;
    logic [2*FIELD_BITS-1:0] m0, m1, m2;
    logic [HASH_BITS-1:0] hsum;
    logic [AW:0] mod_t;
    logic [AW-1:0] mod_r;
    logic [MOD_STEP_BITS-1:0] mod_bits;
    logic hit_valid, edge_done, new_edge;
    logic [AW-1:0] pos_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= table_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_lo_reg[res_cnt_reg]  <= key_reg[KW-1:VERTEX_BITS];
            res_hi_reg[res_cnt_reg]  <= key_reg[VERTEX_BITS-1:0];
            res_ovf_reg[res_cnt_reg] <= res_ovf_w;
        end
    end

    always_comb
    begin
        unique case (edge_reg)
            EDGE_AB:
            begin
                ep = va_reg;
                eq = vb_reg;
            end
            EDGE_BC:
            begin
                ep = vb_reg;
                eq = vc_reg;
            end
            default:
            begin
                ep = vc_reg;
                eq = va_reg;
            end
        endcase
        elo = (ep < eq) ? ep : eq;
        ehi = (ep < eq) ? eq : ep;
        m0 = FIELD_BITS'(ehi) * HASH_MULT_LO;
        m1 = FIELD_BITS'(elo) * HASH_MULT_LO;
        m2 = FIELD_BITS'(ehi) * HASH_MULT_HI;
        hsum = p0_reg + {p1_reg + p2_reg, {FIELD_BITS{1'b0}}};
        mod_bits = h_reg[HASH_BITS-1 -: MOD_STEP_BITS];
        mod_r = rem_reg;
        for (int i = 0; i < MOD_STEP_BITS; i++)
        begin
            mod_t = {mod_r, mod_bits[MOD_STEP_BITS-1-i]};
            if (mod_t >= (AW+1)'(TABLE_ENTRIES))
            begin
                mod_t = mod_t - (AW+1)'(TABLE_ENTRIES);
            end
            mod_r = mod_t[AW-1:0];
        end
        pos_inc = (pos_reg == AW'(TABLE_ENTRIES - 1)) ? '0 : pos_reg + 1'b1;
        hit_valid = (rdata_reg[WW-1 -: EPOCH_BITS] == epoch_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        vc_next       = vc_reg;
        edge_next     = edge_reg;
        key_next      = key_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        h_next        = h_reg;
        rem_next      = rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        pos_next      = pos_reg;
        probe_next    = probe_reg;
        count_next    = count_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = pend_reg;
        res_cnt_next  = res_cnt_reg;
        emit_idx_next = emit_idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = {epoch_reg, key_reg};
        res_we        = 1'b0;
        res_ovf_w     = 1'b0;
        edge_done     = 1'b0;
        new_edge      = 1'b0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    va_next      = vertex_a[VERTEX_BITS-1:0];
                    vb_next      = vertex_b[VERTEX_BITS-1:0];
                    vc_next      = vertex_c[VERTEX_BITS-1:0];
                    edge_next    = EDGE_AB;
                    res_cnt_next = '0;
                    pend_next    = 1'b1;
                    state_next   = ST_HASH_MUL;
                    if (start_of_mesh)
                    begin
                        count_next = '0;
                        epoch_next = epoch_reg + 1'b1;
                        if (epoch_reg == {EPOCH_BITS{1'b1}})
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(TABLE_ENTRIES - 1))
                begin
                    clr_addr_next = '0;
                    epoch_next    = EPOCH_BITS'(1);
                    state_next    = pend_reg ? ST_HASH_MUL : ST_IDLE;
                end
            end
            ST_HASH_MUL:
            begin
                key_next   = {elo, ehi};
                p0_next    = m0;
                p1_next    = m1[FIELD_BITS-1:0];
                p2_next    = m2[FIELD_BITS-1:0];
                state_next = ST_HASH_SUM;
            end
            ST_HASH_SUM:
            begin
                h_next       = hsum ^ (hsum >> HASH_XOR_SHIFT);
                rem_next     = '0;
                mod_cnt_next = '0;
                probe_next   = '0;
                if (IS_POW2)
                begin
                    pos_next   = h_next[AW-1:0];
                    state_next = ST_PROBE_RD;
                end
                else
                begin
                    state_next = ST_HASH_MOD;
                end
            end
            ST_HASH_MOD:
            begin
                rem_next     = mod_r;
                h_next       = h_reg << MOD_STEP_BITS;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == $bits(mod_cnt_reg)'(MOD_STEPS - 1))
                begin
                    pos_next   = mod_r;
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CMP;
            end
            ST_PROBE_CMP:
            begin
                if (!hit_valid)
                begin
                    new_edge  = 1'b1;
                    edge_done = 1'b1;
                    if (count_reg < CW'(TABLE_ENTRIES))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_ovf_w = 1'b1;
                    end
                end
                else if (rdata_reg[KW-1:0] == key_reg)
                begin
                    edge_done = 1'b1;
                end
                else if (probe_reg == CW'(TABLE_ENTRIES - 1))
                begin
                    new_edge  = 1'b1;
                    edge_done = 1'b1;
                    res_ovf_w = 1'b1;
                end
                else
                begin
                    pos_next   = pos_inc;
                    probe_next = probe_reg + 1'b1;
                    state_next = ST_PROBE_RD;
                end
                if (new_edge)
                begin
                    res_we       = 1'b1;
                    res_cnt_next = res_cnt_reg + 1'b1;
                end
                if (edge_done)
                begin
                    if (edge_reg == EDGE_CA)
                    begin
                        emit_idx_next = '0;
                        if (res_cnt_next != '0)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            pend_next  = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        edge_next  = (edge_reg == EDGE_AB) ? EDGE_BC : EDGE_CA;
                        state_next = ST_HASH_MUL;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    emit_idx_next = emit_idx_reg + 1'b1;
                    if (emit_idx_next == res_cnt_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign edge_low         = FIELD_BITS'(res_lo_reg[emit_idx_reg]);
    assign edge_high        = FIELD_BITS'(res_hi_reg[emit_idx_reg]);
    assign table_overflow   = res_ovf_reg[emit_idx_reg];
    assign last_of_triangle = ((emit_idx_reg + 1'b1) == res_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            edge_reg     <= EDGE_AB;
            mod_cnt_reg  <= '0;
            probe_reg    <= '0;
            count_reg    <= '0;
            epoch_reg    <= '0;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            res_cnt_reg  <= '0;
            emit_idx_reg <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            edge_reg     <= edge_next;
            mod_cnt_reg  <= mod_cnt_next;
            probe_reg    <= probe_next;
            count_reg    <= count_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            res_cnt_reg  <= res_cnt_next;
            emit_idx_reg <= emit_idx_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg  <= va_next;
        vb_reg  <= vb_next;
        vc_reg  <= vc_next;
        key_reg <= key_next;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        h_reg   <= h_next;
        rem_reg <= rem_next;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import tde_pkg::*;

    localparam int TABLE_SIZE = 4096;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        bit [FIELD_BITS-1:0] lo;
        bit [FIELD_BITS-1:0] hi;
        bit                  last;
        bit                  ovf;
    } edge_res_t;

    typedef struct {
        bit                  som;
        bit [FIELD_BITS-1:0] a;
        bit [FIELD_BITS-1:0] b;
        bit [FIELD_BITS-1:0] c;
        int                  n;
        bit [2:0][FIELD_BITS-1:0] lo;
        bit [2:0][FIELD_BITS-1:0] hi;
    } tri_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  start_of_mesh;
    logic [FIELD_BITS-1:0] vertex_a;
    logic [FIELD_BITS-1:0] vertex_b;
    logic [FIELD_BITS-1:0] vertex_c;
    logic                  out_valid;
    logic                  out_ready;
    logic [FIELD_BITS-1:0] edge_low;
    logic [FIELD_BITS-1:0] edge_high;
    logic                  last_of_triangle;
    logic                  table_overflow;

    bit [63:0]   key_store[TABLE_SIZE];
    bit          key_taken[TABLE_SIZE];
    int unsigned keys_held;

    edge_res_t   new_edges[$];
    edge_res_t   pending_edges[$];
    tri_row_t    directed_rows[$];

    int  mismatches;
    int  edges_seen;
    int  overflow_seen;
    int  triangles_sent;
    bit  no_idle;

    triangle_edge_dedup u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_of_mesh    (start_of_mesh),
        .vertex_a         (vertex_a),
        .vertex_b         (vertex_b),
        .vertex_c         (vertex_c),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .edge_low         (edge_low),
        .edge_high        (edge_high),
        .last_of_triangle (last_of_triangle),
        .table_overflow   (table_overflow)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit [11:0] hash_slot(bit [63:0] key);
        bit [63:0] h;
        h = key * 64'h9E3779B97F4A7C15;
        h = h ^ (h >> 29);
        return h[11:0];
    endfunction

    function automatic bit insert_key(bit [63:0] key, output bit ovf);
        int unsigned pos;
        pos = hash_slot(key);
        ovf = 1'b0;
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            if (!key_taken[pos])
            begin
                if (keys_held < TABLE_SIZE)
                begin
                    key_store[pos] = key;
                    key_taken[pos] = 1'b1;
                    keys_held++;
                end
                else
                begin
                    ovf = 1'b1;
                end
                return 1'b1;
            end
            if (key_store[pos] == key)
                return 1'b0;
            pos = (pos + 1) % TABLE_SIZE;
        end
        ovf = 1'b1;
        return 1'b1;
    endfunction

    function automatic void find_new_edges(bit som, bit [FIELD_BITS-1:0] a,
                                           bit [FIELD_BITS-1:0] b, bit [FIELD_BITS-1:0] c);
        bit [FIELD_BITS-1:0] v[3];
        bit [FIELD_BITS-1:0] p;
        bit [FIELD_BITS-1:0] q;
        edge_res_t r;
        bit ovf;
        new_edges.delete();
        if (som)
        begin
            foreach (key_taken[i])
                key_taken[i] = 1'b0;
            keys_held = 0;
        end
        v[0] = a;
        v[1] = b;
        v[2] = c;
        for (int e = 0; e < 3; e++)
        begin
            p = v[e];
            q = v[(e + 1) % 3];
            r.lo = (p < q) ? p : q;
            r.hi = (p < q) ? q : p;
            r.last = 1'b0;
            if (insert_key({r.lo, r.hi}, ovf))
            begin
                r.ovf = ovf;
                new_edges = {new_edges, r};
            end
        end
        if (new_edges.size() > 0)
            new_edges[new_edges.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_triangle(bit som, bit [FIELD_BITS-1:0] a, bit [FIELD_BITS-1:0] b,
                                 bit [FIELD_BITS-1:0] c, int typed_n,
                                 bit [2:0][FIELD_BITS-1:0] typed_lo,
                                 bit [2:0][FIELD_BITS-1:0] typed_hi);
        int gap;
        edge_res_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        start_of_mesh <= som;
        vertex_a      <= a;
        vertex_b      <= b;
        vertex_c      <= c;
        do
            @(posedge clk);
        while (!in_ready);
        find_new_edges(som, a, b, c);
        if (typed_n < 0)
        begin
            foreach (new_edges[i])
                pending_edges = {pending_edges, new_edges[i]};
        end
        else
        begin
            for (int i = 0; i < typed_n; i++)
            begin
                r.lo   = typed_lo[i];
                r.hi   = typed_hi[i];
                r.last = (i == typed_n - 1);
                r.ovf  = 1'b0;
                pending_edges = {pending_edges, r};
            end
        end
        triangles_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(bit som, bit [FIELD_BITS-1:0] a, bit [FIELD_BITS-1:0] b,
                              bit [FIELD_BITS-1:0] c);
        send_triangle(som, a, b, c, -1, '0, '0);
    endtask

    function automatic void add_row(bit som, bit [FIELD_BITS-1:0] a, bit [FIELD_BITS-1:0] b,
                                    bit [FIELD_BITS-1:0] c, int n,
                                    bit [2:0][FIELD_BITS-1:0] lo,
                                    bit [2:0][FIELD_BITS-1:0] hi);
        tri_row_t row;
        row.som = som;
        row.a   = a;
        row.b   = b;
        row.c   = c;
        row.n   = n;
        row.lo  = lo;
        row.hi  = hi;
        directed_rows = {directed_rows, row};
    endfunction

    // Receiver back-pressure: mostly short stalls, occasionally long ones.
    int stall_left;
    always @(negedge clk)
    begin
        if (!rst_n || no_idle)
        begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 70)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready  <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        edge_res_t want;
        edge_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.lo   = edge_low;
            got.hi   = edge_high;
            got.last = last_of_triangle;
            got.ovf  = table_overflow;
            edges_seen++;
            if (got.ovf)
                overflow_seen++;
            if (pending_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected transaction: low %h high %h last %b ovf %b",
                             got.lo, got.hi, got.last, got.ovf);
            end
            else
            begin
                want = pending_edges.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"Mismatch: expected low %h high %h last %b ovf %b, ",
                                  "got low %h high %h last %b ovf %b"},
                                 want.lo, want.hi, want.last, want.ovf,
                                 got.lo, got.hi, got.last, got.ovf);
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("Timed out with %0d transactions still expected.", pending_edges.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        bit [FIELD_BITS-1:0] pool[8];
        bit                  slot_used[TABLE_SIZE];
        bit [FIELD_BITS-1:0] v;
        bit [FIELD_BITS-1:0] x;
        bit [FIELD_BITS-1:0] y;
        bit [FIELD_BITS-1:0] tri_v[3];
        bit [FIELD_BITS-1:0] filled[$];
        bit                  som;
        int                  wait_cycles;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        start_of_mesh = 1'b0;
        vertex_a      = '0;
        vertex_b      = '0;
        vertex_c      = '0;
        mismatches    = 0;
        edges_seen    = 0;
        overflow_seen = 0;
        triangles_sent = 0;
        keys_held     = 0;
        no_idle       = 1'b0;
        foreach (key_taken[i])
            key_taken[i] = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(1, 32'h0, 32'h0, 32'h0, 1, '0, '0);
        add_row(0, 32'h0, 32'h0, 32'h0, 0, '0, '0);
        add_row(1, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 2,
                {32'h0, 32'hFFFFFFFF, 32'h0}, {32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF});
        add_row(0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 0, '0, '0);
        add_row(0, 32'h1, 32'h2, 32'h3, -1, '0, '0);
        add_row(0, 32'h3, 32'h2, 32'h4, -1, '0, '0);
        add_row(0, 32'h4, 32'h1, 32'h3, -1, '0, '0);
        add_row(0, 32'h3, 32'h1, 32'h2, -1, '0, '0);
        add_row(0, 32'h5, 32'h5, 32'h6, -1, '0, '0);
        add_row(0, 32'h6, 32'h5, 32'h5, -1, '0, '0);
        add_row(0, 32'h7, 32'h7, 32'h7, -1, '0, '0);
        add_row(1, 32'h80000000, 32'h7FFFFFFF, 32'h1, -1, '0, '0);
        add_row(0, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, -1, '0, '0);
        add_row(0, 32'h55555555, 32'hAAAAAAAA, 32'h80000000, -1, '0, '0);
        add_row(1, 32'h1, 32'h2, 32'h3, -1, '0, '0);
        add_row(0, 32'h2, 32'h1, 32'h3, -1, '0, '0);

        foreach (directed_rows[i])
            send_triangle(directed_rows[i].som, directed_rows[i].a, directed_rows[i].b,
                          directed_rows[i].c, directed_rows[i].n,
                          directed_rows[i].lo, directed_rows[i].hi);

        // Fill the set to capacity with self-edges that hash to distinct slots, so that
        // every probe is short until the set is full.
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        v = $urandom();
        while (filled.size() < TABLE_SIZE)
        begin
            v = v + 1;
            if (!slot_used[hash_slot({v, v})])
            begin
                slot_used[hash_slot({v, v})] = 1'b1;
                filled = {filled, v};
            end
        end
        foreach (filled[i])
            send_plain(i == 0, filled[i], filled[i], filled[i]);

        // With the set full, new edges come out flagged and are not stored.
        send_plain(0, filled[5], filled[5], filled[5]);
        x = $urandom();
        y = $urandom();
        send_plain(0, x, y, x);
        send_plain(0, filled[17], filled[900], filled[17]);
        send_plain(0, x, y, x);

        for (int n = 0; n < 450; n++)
        begin
            som = (n == 0) || ($urandom_range(0, 19) == 0);
            if (som)
                foreach (pool[i])
                    case ($urandom_range(0, 5))
                        0: pool[i] = 32'h0;
                        1: pool[i] = 32'hFFFFFFFF;
                        default: pool[i] = $urandom();
                    endcase
            if (n % 100 == 50)
                no_idle = ~no_idle;
            for (int k = 0; k < 3; k++)
                tri_v[k] = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 7)]
                                                        : $urandom();
            send_plain(som, tri_v[0], tri_v[1], tri_v[2]);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        wait_cycles = 0;
        while (pending_edges.size() > 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);

        $display("Sent %0d triangles, checked %0d edge transactions, %0d of them overflowed.",
                 triangles_sent, edges_seen, overflow_seen);
        $display("Covered degenerate and repeated edges, mesh restarts and a full edge set.");
        if (mismatches == 0 && pending_edges.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d transactions missing.", mismatches,
                     pending_edges.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
